[hdl/tsfm_pkg.sv]
package tsfm_pkg;

	// Command codes of an input item.
	localparam logic [1:0] CMD_DATA     = 2'd0;
	localparam logic [1:0] CMD_DATA_PAD = 2'd1;
	localparam logic [1:0] CMD_PAD      = 2'd2;
	// The spare code behaves like a plain pad command.
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	localparam logic [3:0] FLAG_SLOT       = 4'd15;
	localparam logic [3:0] LAST_SLOT       = 4'd14;
	localparam logic [3:0] FWI_MAX         = 4'd15;
	localparam logic [3:0] ID_REPEAT_RESET = 4'd15;
	localparam logic [7:0] DATA_MASK       = 8'hFE;
	localparam logic [7:0] PAD_ID_BYTE     = 8'h01;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic [6:0] source_id;
	} item_t;

	// Sixteen frame bytes, byte 0 in bits 7:0.
	typedef logic [15:0][7:0] frame_t;

	// Halves produced by one item, first half at index 0.
	typedef struct packed {
		logic [2:0]        n_halves;
		logic [3:0][63:0]  halves;
	} burst_t;

endpackage

[hdl/tsfm_in_if.sv]
interface tsfm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	logic [6:0] source_id;

	modport source (output valid, cmd, data_byte, source_id, input ready);
	modport sink (input valid, cmd, data_byte, source_id, output ready);
endinterface

[hdl/tsfm_out_if.sv]
interface tsfm_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] frame_half;
	logic        upper_half;
	logic        last_of_run;

	modport source (output valid, frame_half, upper_half, last_of_run, input ready);
	modport sink (input valid, frame_half, upper_half, last_of_run, output ready);
endinterface

[hdl/tsfm_packer.sv]
module tsfm_packer
	import tsfm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	input  logic       advance,
	input  item_t      item,
	output burst_t     burst
);

	frame_t     frame_q;
	logic [3:0] slot_q;
	logic [6:0] cur_id_q;
	logic [3:0] fwi_q;
	logic [3:0] rep_q;

	frame_t     frame_nx;
	logic [3:0] slot_nx;
	logic [6:0] cur_id_nx;
	logic [3:0] fwi_nx;

	function automatic logic [3:0] fwi_inc(input logic [3:0] v);
		fwi_inc = (v == FWI_MAX) ? v : v + 4'd1;
	endfunction

	always_comb begin
		frame_t     fb;
		frame_t     frame_a;
		frame_t     frame_b;
		frame_t     frame_0;
		logic [3:0] slot;
		logic [3:0] s;
		logic [3:0] s_m1;
		logic [3:0] s_p1;
		logic [3:0] s_p2;
		logic [6:0] cur;
		logic [3:0] fwi;
		logic       do_place;
		logic       do_pad;
		logic       new_id;
		logic       need_id;
		logic       emit_a;
		logic       emit_b;
		logic [7:0] moved;

		fb      = frame_q;
		slot    = slot_q;
		cur     = cur_id_q;
		fwi     = fwi_q;
		frame_a = frame_q;
		frame_b = frame_q;
		emit_a  = 1'b0;
		emit_b  = 1'b0;
		moved   = '0;
		need_id = 1'b0;

		case (item.cmd)
			CMD_DATA: begin
				do_place = 1'b1;
				do_pad   = 1'b0;
			end
			CMD_DATA_PAD: begin
				do_place = 1'b1;
				do_pad   = 1'b1;
			end
			default: begin
				do_place = 1'b0;
				do_pad   = 1'b1;
			end
		endcase

		// Place the data byte, inserting the source ID where it is due.
		new_id = (item.source_id != cur);
		s      = slot;
		s_m1   = s - 4'd1;
		s_p1   = s + 4'd1;
		s_p2   = s + 4'd2;
		if (do_place) begin
			if (!s[0]) begin
				need_id = new_id || ((s == 4'd0) && (fwi >= rep_q));
				if (!need_id) begin
					fb[s] = item.data_byte & DATA_MASK;
					if (item.data_byte[0])
						fb[FLAG_SLOT][s[3:1]] = 1'b1;
					slot = s_p1;
				end else begin
					fb[s] = {item.source_id, 1'b1};
					cur   = item.source_id;
					fwi   = 4'd0;
					if (s != LAST_SLOT) begin
						fb[s_p1] = item.data_byte;
						slot     = s_p2;
					end else begin
						// The ID closed the frame; the byte opens the next one, after the ID again if rep_q <= 1.
						emit_a  = 1'b1;
						frame_a = fb;
						fb      = '0;
						fwi     = 4'd1;
						if (rep_q <= 4'd1) begin
							fb[0] = {item.source_id, 1'b1};
							fb[1] = item.data_byte;
							fwi   = 4'd0;
							slot  = 4'd2;
						end else begin
							fb[0]            = item.data_byte & DATA_MASK;
							fb[FLAG_SLOT][0] = item.data_byte[0];
							slot             = 4'd1;
						end
					end
				end
			end else begin
				if (new_id) begin
					// The previous byte moves up whole and its flag marks the old ID.
					moved                       = fb[s_m1] | {7'd0, fb[FLAG_SLOT][s_m1[3:1]]};
					fb[s]                       = moved;
					fb[s_m1]                    = {item.source_id, 1'b1};
					fb[FLAG_SLOT][s_m1[3:1]]    = 1'b1;
					cur                         = item.source_id;
					fwi                         = 4'd0;
					fb[s_p1]                    = item.data_byte & DATA_MASK;
					if (item.data_byte[0])
						fb[FLAG_SLOT][s_p1[3:1]] = 1'b1;
					slot = s_p2;
				end else begin
					fb[s] = item.data_byte;
					slot  = s_p1;
				end
			end
			if (slot == FLAG_SLOT) begin
				emit_a  = 1'b1;
				frame_a = fb;
				fb      = '0;
				slot    = 4'd0;
				fwi     = fwi_inc(fwi);
			end
		end

		// Pad out the open frame with ID 0 and zero bytes.
		s    = slot;
		s_m1 = s - 4'd1;
		if (do_pad && (s != 4'd0)) begin
			if (s == LAST_SLOT) begin
				fb[LAST_SLOT] = PAD_ID_BYTE;
				cur           = 7'd0;
				fwi           = 4'd0;
			end else if (cur != 7'd0) begin
				if (!s[0]) begin
					fb[s] = PAD_ID_BYTE;
				end else begin
					moved                    = fb[s_m1] | {7'd0, fb[FLAG_SLOT][s_m1[3:1]]};
					fb[s]                    = moved;
					fb[s_m1]                 = PAD_ID_BYTE;
					fb[FLAG_SLOT][s_m1[3:1]] = 1'b1;
				end
				cur = 7'd0;
				fwi = 4'd0;
			end
			emit_b  = 1'b1;
			frame_b = fb;
			fb      = '0;
			slot    = 4'd0;
			fwi     = fwi_inc(fwi);
		end

		frame_0        = emit_a ? frame_a : frame_b;
		burst.n_halves = {emit_a & emit_b, emit_a ^ emit_b, 1'b0};
		burst.halves   = {frame_b, frame_0};

		frame_nx  = fb;
		slot_nx   = slot;
		cur_id_nx = cur;
		fwi_nx    = fwi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= '0;
			slot_q   <= '0;
			cur_id_q <= '0;
			fwi_q    <= '0;
			rep_q    <= ID_REPEAT_RESET;
		end else begin
			if (cfg_wr_en)
				rep_q <= cfg_wr_data;
			if (advance) begin
				frame_q  <= frame_nx;
				slot_q   <= slot_nx;
				cur_id_q <= cur_id_nx;
				fwi_q    <= fwi_nx;
			end
		end
	end

endmodule

[hdl/tsfm_out_buf.sv]
module tsfm_out_buf
	import tsfm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  burst_t        burst,
	output logic          free,
	tsfm_out_if.source    out_ch
);

	logic [3:0][63:0] halves_q;
	logic [2:0]       rem_q;
	logic [1:0]       rd_q;
	logic             take;

	assign out_ch.valid       = (rem_q != 3'd0);
	assign out_ch.frame_half  = halves_q[rd_q];
	assign out_ch.upper_half  = rd_q[0];
	assign out_ch.last_of_run = (rem_q == 3'd1);

	assign take = out_ch.valid && out_ch.ready;
	// The buffer can take a new burst once its last half leaves.
	assign free = (rem_q == 3'd0) || (take && (rem_q == 3'd1));

	always_ff @(posedge clk) begin
		if (load && free)
			halves_q <= burst.halves;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (load && free) begin
			rem_q <= burst.n_halves;
			rd_q  <= '0;
		end else if (take) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

endmodule

[hdl/trace_source_frame_mux_top.sv]
// Channel    Dir  Payload                                    Handshake
// item_in    in   cmd[1:0], data_byte[7:0], source_id[6:0]   valid/ready
// frame_out  out  frame_half[63:0], upper_half, last_of_run  valid/ready
// cfg        in   cfg_wr_data[3:0] (id_repeat_frames)        cfg_wr_en
//
// An item is registered and packed combinationally; its frame halves (zero,
// two or four) load into the output buffer when it is free. The buffer drains
// one half per cycle while frame_out is ready, and the next item waits until
// the halves drain; items that complete no frame pass at one per cycle while
// the buffer is empty. Reset clears the frame, slot counter and current ID.
// A stall on frame_out backs up into item_in ready.
module trace_source_frame_mux_top
	import tsfm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	tsfm_in_if.sink     item_in,
	tsfm_out_if.source  frame_out
);

	item_t  item_s1;
	logic   valid_s1;
	logic   advance;
	logic   buf_free;
	burst_t burst;

	assign advance       = valid_s1 && buf_free;
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			item_s1.cmd       <= item_in.cmd;
			item_s1.data_byte <= item_in.data_byte;
			item_s1.source_id <= item_in.source_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	tsfm_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.item        (item_s1),
		.burst       (burst)
	);

	tsfm_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.burst  (burst),
		.free   (buf_free),
		.out_ch (frame_out)
	);

endmodule

[verif/tsfm_frame_checker.sv]
module tsfm_frame_checker
	import tsfm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	tsfm_in_if         item_in,
	tsfm_out_if        frame_out,
	output int         errors,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [63:0] half;
		logic        upper;
		logic        is_last;
	} frame_half_t;

	frame_t      frame_store;
	logic [3:0]  slot_idx;
	logic [6:0]  cur_src;
	logic [3:0]  frames_no_id;
	logic [3:0]  repeat_cfg;
	frame_half_t half_q[$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (errors < MAX_PRINTED) begin
			$display("%0t ns: %s mismatch, got %h expected %h", $realtime, what, got, want);
		end
		errors++;
	endtask

	task automatic emit_frame_halves();
		frame_half_t lo_half;
		frame_half_t hi_half;
		lo_half = '{half: frame_store[7:0], upper: 1'b0, is_last: 1'b0};
		hi_half = '{half: frame_store[15:8], upper: 1'b1, is_last: 1'b0};
		half_q = {half_q, lo_half, hi_half};
		frame_store = '0;
		slot_idx = 4'd0;
		if (frames_no_id < FWI_MAX) begin
			frames_no_id++;
		end
	endtask

	task automatic write_src_id(input logic [3:0] s, input logic [6:0] id);
		frame_store[s] = {id, 1'b1};
		cur_src = id;
		frames_no_id = 4'd0;
	endtask

	task automatic place_trace_byte(input logic [6:0] id, input logic [7:0] b);
		logic       need_id;
		logic       placed;
		logic [3:0] s;
		logic [3:0] prev;
		logic [7:0] flag_bit;
		need_id = (id != cur_src);
		placed = 1'b0;
		while (!placed) begin
			s = slot_idx;
			if (s >= FLAG_SLOT) begin
				emit_frame_halves();
			end else if (s[0]) begin
				if (need_id) begin
					// The data byte in the even slot moves up so that the new ID can
					// take its place; its flag then marks it as the old source's.
					prev = s - 4'd1;
					flag_bit = 8'd1 << prev[3:1];
					frame_store[s] = frame_store[prev] |
						{7'd0, (frame_store[FLAG_SLOT] & flag_bit) != 8'd0};
					write_src_id(prev, id);
					frame_store[FLAG_SLOT] |= flag_bit;
					need_id = 1'b0;
					slot_idx = s + 4'd1;
				end else begin
					frame_store[s] = b;
					slot_idx = s + 4'd1;
					placed = 1'b1;
				end
			end else begin
				if (s == 4'd0 && frames_no_id >= repeat_cfg) begin
					need_id = 1'b1;
				end
				if (need_id) begin
					write_src_id(s, id);
					need_id = 1'b0;
					slot_idx = s + 4'd1;
				end else begin
					frame_store[s] = b & DATA_MASK;
					if (b[0]) begin
						frame_store[FLAG_SLOT] |= 8'd1 << s[3:1];
					end
					slot_idx = s + 4'd1;
					placed = 1'b1;
				end
			end
		end
		if (slot_idx >= FLAG_SLOT) begin
			emit_frame_halves();
		end
	endtask

	task automatic pad_out_frame();
		if (slot_idx == LAST_SLOT) begin
			write_src_id(LAST_SLOT, 7'd0);
			slot_idx = FLAG_SLOT;
			emit_frame_halves();
		end else begin
			while (slot_idx != 4'd0) begin
				place_trace_byte(7'd0, 8'd0);
			end
		end
	endtask

	task automatic predict_frames(input item_t it);
		int n_before;
		n_before = half_q.size();
		if (it.cmd == CMD_DATA || it.cmd == CMD_DATA_PAD) begin
			place_trace_byte(it.source_id, it.data_byte);
		end
		if (it.cmd != CMD_DATA) begin
			pad_out_frame();
		end
		if (half_q.size() > n_before) begin
			half_q[half_q.size() - 1].is_last = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_half_t want;
		item_t       it;
		if (!arst_n) begin
			frame_store = '0;
			slot_idx = 4'd0;
			cur_src = 7'd0;
			frames_no_id = 4'd0;
			repeat_cfg = ID_REPEAT_RESET;
			half_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_wr_en) begin
				repeat_cfg = cfg_wr_data;
			end
			if (item_in.valid && item_in.ready) begin
				it.cmd = item_in.cmd;
				it.data_byte = item_in.data_byte;
				it.source_id = item_in.source_id;
				predict_frames(it);
			end
			if (frame_out.valid && frame_out.ready) begin
				if (half_q.size() == 0) begin
					report_mismatch("unexpected frame half", frame_out.frame_half, 64'd0);
				end else begin
					want = half_q.pop_front();
					if (frame_out.frame_half !== want.half) begin
						report_mismatch("frame_half", frame_out.frame_half, want.half);
					end
					if (frame_out.upper_half !== want.upper) begin
						report_mismatch("upper_half", {63'd0, frame_out.upper_half},
							{63'd0, want.upper});
					end
					if (frame_out.last_of_run !== want.is_last) begin
						report_mismatch("last_of_run", {63'd0, frame_out.last_of_run},
							{63'd0, want.is_last});
					end
				end
			end
			outstanding = half_q.size();
		end
	end

endmodule

[verif/testbench.sv]
module testbench;
	import tsfm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 80;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;
	int         errors;
	int         outstanding;
	int         cycle_count = 0;
	int         gap_pct;
	int         stall_pct;
	logic [6:0] last_src;

	tsfm_in_if  item_if();
	tsfm_out_if frame_if();

	trace_source_frame_mux_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_in    (item_if),
		.frame_out  (frame_if)
	);

	tsfm_frame_checker frame_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_in    (item_if),
		.frame_out  (frame_if),
		.errors     (errors),
		.outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Mostly short pauses, now and then a long one.
	function automatic int idle_len(input int pct);
		if ($urandom_range(99) >= pct) begin
			return 0;
		end
		if ($urandom_range(9) == 0) begin
			return $urandom_range(60, 15);
		end
		return $urandom_range(3, 1);
	endfunction

	initial begin
		int stall_left;
		stall_left = 0;
		frame_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				frame_if.ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = idle_len(stall_pct);
				if (stall_left > 0) begin
					frame_if.ready <= 1'b0;
					stall_left--;
				end else begin
					frame_if.ready <= 1'b1;
				end
			end
		end
	end

	// Entered and left just after a falling edge; valid stays high on return.
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
			input logic [6:0] id);
		int gap;
		gap = idle_len(gap_pct);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.cmd <= cmd;
		item_if.data_byte <= b;
		item_if.source_id <= id;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		@(negedge clk);
		if (cmd == CMD_DATA || cmd == CMD_DATA_PAD) begin
			last_src = id;
		end
	endtask

	task automatic drain_frames();
		item_if.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	// The block may still be packing an item that completed no frame.
	task automatic set_id_repeat(input logic [3:0] value);
		drain_frames();
		repeat (3) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_random_item();
		logic [1:0] cmd;
		logic [7:0] b;
		logic [6:0] id;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 80) begin
			cmd = CMD_DATA;
		end else if (pick < 90) begin
			cmd = CMD_DATA_PAD;
		end else if (pick < 97) begin
			cmd = CMD_PAD;
		end else begin
			cmd = CMD_RESERVED;
		end
		case ($urandom_range(7))
			0: b = 8'h00;
			1: b = 8'hFF;
			default: b = 8'($urandom_range(255));
		endcase
		// Runs of one source with occasional switches keep the ID logic busy.
		case ($urandom_range(9))
			0, 1, 2, 3: id = last_src;
			4: id = 7'd0;
			5: id = 7'd127;
			6: id = 7'($urandom_range(3, 1));
			default: id = 7'($urandom_range(127));
		endcase
		send_item(cmd, b, id);
	endtask

	initial begin
		logic [3:0] repeat_vals[RANDOM_PHASES];
		int         gap_vals[RANDOM_PHASES];
		int         stall_vals[RANDOM_PHASES];
		repeat_vals = '{4'd0, 4'd1, 4'd15, 4'($urandom_range(14, 2)),
			4'($urandom_range(15)), 4'($urandom_range(15, 1))};
		gap_vals = '{0, 25, 50, 10, 35, 60};
		stall_vals = '{0, 30, 10, 60, 40, 20};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 4'd0;
		item_if.valid = 1'b0;
		item_if.cmd = CMD_DATA;
		item_if.data_byte = 8'd0;
		item_if.source_id = 7'd0;
		last_src = 7'd0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: field extremes, ID changes on both slot parities,
		// padding from an empty frame, from slot 14 and with command three.
		send_item(CMD_DATA, 8'h00, 7'd0);
		send_item(CMD_DATA, 8'hFF, 7'd127);
		send_item(CMD_DATA, 8'h01, 7'd127);
		send_item(CMD_DATA, 8'hFE, 7'd3);
		send_item(CMD_RESERVED, 8'hFF, 7'd127);
		send_item(CMD_PAD, 8'h5A, 7'd9);
		send_item(CMD_DATA_PAD, 8'h80, 7'd0);
		for (int k = 0; k < 14; k++) begin
			send_item(CMD_DATA, k[0] ? 8'h00 : 8'hFF, 7'd0);
		end
		send_item(CMD_PAD, 8'h00, 7'd0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_id_repeat(repeat_vals[ph]);
			gap_pct = gap_vals[ph];
			stall_pct = stall_vals[ph];
			repeat (ITEMS_PER_PHASE) send_random_item();
		end

		drain_frames();
		repeat (10) @(negedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/tsfm_pkg.sv
hdl/tsfm_in_if.sv
hdl/tsfm_out_if.sv
hdl/tsfm_packer.sv
hdl/tsfm_out_buf.sv
hdl/trace_source_frame_mux_top.sv
verif/tsfm_frame_checker.sv
verif/testbench.sv
